FILE: rtl/core/mag_sample_dedup_qualifier_defines.svh
// Assertion helpers for the RTL that checks itself.
`ifndef MAG_SAMPLE_DEDUP_QUALIFIER_DEFINES_SVH
`define MAG_SAMPLE_DEDUP_QUALIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MSDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MSDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/msdq_pkg.sv
package msdq_pkg;

	localparam int unsigned RAW_W    = 16;
	localparam int unsigned FIELD_W  = 21;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned PERIOD_W = 10;
	localparam int unsigned THRESH_W = PERIOD_W + 1;
	localparam int unsigned XYZ_W    = 3 * RAW_W;

	// gauss scale: field = (raw * SCALE_MUL) >>> SCALE_SHIFT
	localparam logic signed [RAW_W-1:0] SCALE_MUL   = 16'sd22370;
	localparam int unsigned             SCALE_SHIFT = 10;

	// period / 10 as (period * DIV10_MUL) >> DIV10_SHIFT, exact below 1029
	localparam logic [7:0]  DIV10_MUL   = 8'd205;
	localparam int unsigned DIV10_SHIFT = 11;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd50;
	localparam logic [THRESH_W-1:0] THRESH_RST = 11'd55;
	localparam logic [THRESH_W-1:0] TWICE_RST  = 11'd100;

	localparam logic CFG_PERIOD = 1'b0;
	localparam logic CFG_CHECK  = 1'b1;

	typedef enum logic [1:0] {
		RSN_OK        = 2'd0,
		RSN_NOT_READY = 2'd1,
		RSN_OVERFLOW  = 2'd2,
		RSN_DUPLICATE = 2'd3
	} msdq_reason_t;

	typedef struct packed {
		logic                data_ready;
		logic                overflow;
		logic                oneshot;
		logic [XYZ_W-1:0]    xyz;
		logic [TIME_W-1:0]   now;
		logic [TIME_W-1:0]   now_minus_p;
	} msdq_smp_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [THRESH_W-1:0] thresh;
		logic [THRESH_W-1:0] twice;
		logic                check_status;
		logic                clear_valid;
	} msdq_cfg_t;

endpackage

FILE: rtl/core/mag_sample_dedup_qualifier.sv
// Magnetometer sample qualifier with duplicate suppression.
// Input channel (in_valid / in_stall): one sample item with status bits,
// one-shot flag, three signed raw axes and a millisecond timestamp.
// Output channel (out_valid / out_stall): one result item per sample:
// accepted, reject_reason and the three axes in gauss, Q.16 (zero on reject).
// Config channel (cfg_valid / cfg_ready, always ready): index 0 writes the
// period in ms and clears the stored-sample mark, index 1 writes check_status.
// Write config only while no item is in flight.
// An item taken is registered in the input register, judged and scaled from
// there, and its result is registered in the output register.
// Throughput: one item per cycle while the receiver takes results; an input
// register and an output register part the two sides, so an item is taken
// while a result waits. On a stall the result holds, an empty input register
// takes one more item, and in_stall then rises until the result is taken.
// Reset clears both pipeline stages, the stored sample, its valid mark and
// its time, and sets period 50 ms and check_status 1.
`include "mag_sample_dedup_qualifier_defines.svh"

module mag_sample_dedup_qualifier
	import msdq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      data_ready,
	input  logic                      overflow,
	input  logic                      oneshot,
	input  logic signed [RAW_W-1:0]   raw_x,
	input  logic signed [RAW_W-1:0]   raw_y,
	input  logic signed [RAW_W-1:0]   raw_z,
	input  logic [TIME_W-1:0]         now_ms,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      accepted,
	output logic [1:0]                reject_reason,
	output logic signed [FIELD_W-1:0] field_x,
	output logic signed [FIELD_W-1:0] field_y,
	output logic signed [FIELD_W-1:0] field_z,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [PERIOD_W-1:0]       cfg_data
);

	logic [PERIOD_W-1:0] period_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [THRESH_W-1:0] twice_q;
	logic                check_q;
	logic                clear_q;
	logic [17:0]         div10_prod;

	msdq_cfg_t           cfg;
	msdq_smp_t           smp_s1;
	logic                valid_s1;
	logic                adv;
	msdq_reason_t        reason;
	logic signed [FIELD_W-1:0] fx;
	logic signed [FIELD_W-1:0] fy;
	logic signed [FIELD_W-1:0] fz;

	logic                      valid_s2;
	logic                      accepted_s2;
	logic [1:0]                reason_s2;
	logic signed [FIELD_W-1:0] fx_s2;
	logic signed [FIELD_W-1:0] fy_s2;
	logic signed [FIELD_W-1:0] fz_s2;

	assign cfg_ready  = 1'b1;
	assign div10_prod = 18'(cfg_data) * 18'(DIV10_MUL);

	// register the config; precompute the duplicate threshold and snap limit on a period write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			thresh_q <= THRESH_RST;
			twice_q  <= TWICE_RST;
			check_q  <= 1'b1;
			clear_q  <= 1'b0;
		end else begin
			clear_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_PERIOD: begin
						period_q <= cfg_data;
						thresh_q <= THRESH_W'(cfg_data)
							+ THRESH_W'(div10_prod >> DIV10_SHIFT);
						twice_q  <= {cfg_data, 1'b0};
						clear_q  <= 1'b1;
					end
					CFG_CHECK: begin
						check_q <= cfg_data[0];
					end
				endcase
			end
		end
	end

	assign cfg.period       = period_q;
	assign cfg.thresh       = thresh_q;
	assign cfg.twice        = twice_q;
	assign cfg.check_status = check_q;
	assign cfg.clear_valid  = clear_q;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			smp_s1.data_ready  <= data_ready;
			smp_s1.overflow    <= overflow;
			smp_s1.oneshot     <= oneshot;
			smp_s1.xyz         <= {raw_z, raw_y, raw_x};
			smp_s1.now         <= now_ms;
			smp_s1.now_minus_p <= now_ms - TIME_W'(period_q);
		end
	end

	msdq_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (valid_s1 && adv),
		.smp    (smp_s1),
		.reason (reason)
	);

	msdq_scale u_scale_x (.raw(smp_s1.xyz[0 +: RAW_W]),       .field(fx));
	msdq_scale u_scale_y (.raw(smp_s1.xyz[RAW_W +: RAW_W]),   .field(fy));
	msdq_scale u_scale_z (.raw(smp_s1.xyz[2*RAW_W +: RAW_W]), .field(fz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	// register the verdict and the fields, zeroing the fields of a rejected item
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			accepted_s2 <= (reason == RSN_OK);
			reason_s2   <= reason;
			fx_s2       <= (reason == RSN_OK) ? fx : '0;
			fy_s2       <= (reason == RSN_OK) ? fy : '0;
			fz_s2       <= (reason == RSN_OK) ? fz : '0;
		end
	end

	assign out_valid     = valid_s2;
	assign accepted      = accepted_s2;
	assign reject_reason = reason_s2;
	assign field_x       = fx_s2;
	assign field_y       = fy_s2;
	assign field_z       = fz_s2;

	`MSDQ_ASSERT_NOW(a_stall_only_when_full, in_stall,
		valid_s1 && out_valid && out_stall, "input stalled without a blocked result")
	`MSDQ_ASSERT_NOW(a_accept_matches_reason, out_valid,
		accepted == (reject_reason == RSN_OK), "accepted disagrees with reject_reason")
	`MSDQ_ASSERT_NOW(a_reject_zero_fields, out_valid && !accepted,
		field_x == '0 && field_y == '0 && field_z == '0, "rejected item has nonzero fields")
	`MSDQ_ASSERT_NEXT(a_period_write_clears, cfg_valid && cfg_ready && cfg_index == CFG_PERIOD,
		clear_q && thresh_q >= THRESH_W'(period_q), "period write did not update threshold")

endmodule

FILE: rtl/core/msdq_scale.sv
module msdq_scale
	import msdq_pkg::*;
(
	input  logic signed [RAW_W-1:0]   raw,
	output logic signed [FIELD_W-1:0] field
);

	logic signed [2*RAW_W-1:0] prod;

	assign prod  = 32'(raw) * 32'(SCALE_MUL);
	// arithmetic shift: keep bits above the fraction, product fits in 31 bits
	assign field = prod[SCALE_SHIFT +: FIELD_W];

endmodule

FILE: rtl/core/msdq_track.sv
module msdq_track
	import msdq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  msdq_cfg_t    cfg,
	input  logic         step,
	input  msdq_smp_t    smp,
	output msdq_reason_t reason
);

	logic [XYZ_W-1:0]  stored_q;
	logic              valid_q;
	logic [TIME_W-1:0] time_q;

	msdq_reason_t      status;
	logic              same;
	logic [TIME_W-1:0] d;
	logic [TIME_W-1:0] lag;
	logic [TIME_W-1:0] next_time;

	always_comb begin
		status = RSN_OK;
		if (smp.oneshot) begin
			if (smp.overflow)
				status = RSN_OVERFLOW;
		end else if (cfg.check_status) begin
			if (!smp.data_ready)
				status = RSN_NOT_READY;
			else if (smp.overflow)
				status = RSN_OVERFLOW;
		end
	end

	assign same = valid_q && (smp.xyz == stored_q);
	assign d    = smp.now - time_q;
	// now minus the advanced time: (now - period) - time
	assign lag  = smp.now_minus_p - time_q;

	always_comb begin
		reason    = status;
		next_time = smp.now;
		if (status == RSN_OK && same) begin
			if (d < TIME_W'(cfg.thresh))
				reason = RSN_DUPLICATE;
			else if (lag > TIME_W'(cfg.twice))
				next_time = smp.now;
			else
				next_time = time_q + TIME_W'(cfg.period);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			valid_q  <= 1'b0;
			time_q   <= '0;
		end else if (cfg.clear_valid) begin
			valid_q <= 1'b0;
		end else if (step && reason == RSN_OK) begin
			stored_q <= smp.xyz;
			valid_q  <= 1'b1;
			time_q   <= next_time;
		end
	end

endmodule

FILE: sim/mag_sample_dedup_qualifier_tb.sv
module mag_sample_dedup_qualifier_tb;
	import msdq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GAUSS_MUL   = 22370;
	localparam int GAUSS_SHIFT = 10;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 54;

	typedef struct {
		logic                    data_ready;
		logic                    overflow;
		logic                    oneshot;
		logic signed [RAW_W-1:0] x;
		logic signed [RAW_W-1:0] y;
		logic signed [RAW_W-1:0] z;
		logic [TIME_W-1:0]       now;
	} mag_sample_t;

	typedef struct {
		logic                      accepted;
		msdq_reason_t              reason;
		logic signed [FIELD_W-1:0] fx;
		logic signed [FIELD_W-1:0] fy;
		logic signed [FIELD_W-1:0] fz;
	} field_result_t;

	class mag_scoreboard;
		logic [PERIOD_W-1:0] period;
		logic                check_on;
		logic [XYZ_W-1:0]    held_xyz;
		logic                held_ok;
		logic [TIME_W-1:0]   stamp;
		field_result_t       expected_q[$];
		int                  errors;
		int                  checked;
		int                  reason_count[4];

		function new();
			period = 10'd50;
			check_on = 1'b1;
			held_xyz = '0;
			held_ok = 1'b0;
			stamp = '0;
			errors = 0;
			checked = 0;
			foreach (reason_count[i])
				reason_count[i] = 0;
		endfunction

		function void set_reg(logic idx, logic [PERIOD_W-1:0] data);
			if (idx == CFG_PERIOD) begin
				period = data;
				held_ok = 1'b0;
			end else begin
				check_on = data[0];
			end
		endfunction

		function logic signed [FIELD_W-1:0] to_gauss(logic signed [RAW_W-1:0] r);
			int prod;
			prod = int'(r) * GAUSS_MUL;
			prod = prod >>> GAUSS_SHIFT;
			return prod[FIELD_W-1:0];
		endfunction

		function void note_sample(mag_sample_t s);
			field_result_t     want;
			logic [XYZ_W-1:0]  xyz;
			logic [TIME_W-1:0] thresh;
			logic [TIME_W-1:0] twice;
			logic [TIME_W-1:0] lag;
			xyz = {s.z, s.y, s.x};
			thresh = TIME_W'(period) + TIME_W'(period / 10);
			twice = TIME_W'(period) << 1;
			want.accepted = 1'b0;
			want.reason = RSN_OK;
			want.fx = '0;
			want.fy = '0;
			want.fz = '0;
			if (s.oneshot) begin
				if (s.overflow)
					want.reason = RSN_OVERFLOW;
			end else if (check_on) begin
				if (!s.data_ready)
					want.reason = RSN_NOT_READY;
				else if (s.overflow)
					want.reason = RSN_OVERFLOW;
			end
			if (want.reason == RSN_OK) begin
				if (held_ok && xyz == held_xyz) begin
					lag = s.now - stamp;
					if (lag < thresh) begin
						want.reason = RSN_DUPLICATE;
					end else begin
						// advance one period, snap to now if still far behind
						stamp = stamp + TIME_W'(period);
						lag = s.now - stamp;
						if (lag > twice)
							stamp = s.now;
					end
				end else begin
					stamp = s.now;
				end
			end
			if (want.reason == RSN_OK) begin
				held_xyz = xyz;
				held_ok = 1'b1;
				want.accepted = 1'b1;
				want.fx = to_gauss(s.x);
				want.fy = to_gauss(s.y);
				want.fz = to_gauss(s.z);
			end
			reason_count[want.reason]++;
			expected_q.push_back(want);
		endfunction

		function void check_result(field_result_t got);
			field_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with no sample pending: acc=%0b rsn=%s",
						$realtime, got.accepted, got.reason.name());
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.accepted !== want.accepted || got.reason !== want.reason ||
				got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: mismatch exp acc=%0b rsn=%s x=%0d y=%0d z=%0d",
						$realtime, want.accepted, want.reason.name(), want.fx, want.fy,
						want.fz);
					$display("%0t:          got acc=%0b rsn=%s x=%0d y=%0d z=%0d",
						$realtime, got.accepted, got.reason.name(), got.fx, got.fy,
						got.fz);
				end
			end
		endfunction

		function int waiting();
			return expected_q.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      data_ready = 1'b0;
	logic                      overflow = 1'b0;
	logic                      oneshot = 1'b0;
	logic signed [RAW_W-1:0]   raw_x = '0;
	logic signed [RAW_W-1:0]   raw_y = '0;
	logic signed [RAW_W-1:0]   raw_z = '0;
	logic [TIME_W-1:0]         now_ms = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      accepted;
	logic [1:0]                reject_reason;
	logic signed [FIELD_W-1:0] field_x;
	logic signed [FIELD_W-1:0] field_y;
	logic signed [FIELD_W-1:0] field_z;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic                      cfg_index = 1'b0;
	logic [PERIOD_W-1:0]       cfg_data = '0;

	mag_scoreboard sb = new();

	bit                      tx_idle_on = 1'b1;
	bit                      rx_idle_on = 1'b1;
	int                      rx_hold = 0;
	int                      rx_len;
	field_result_t           seen;
	logic [TIME_W-1:0]       clock_ms = '0;
	logic signed [RAW_W-1:0] last_x = '0;
	logic signed [RAW_W-1:0] last_y = '0;
	logic signed [RAW_W-1:0] last_z = '0;
	int                      settings_used = 1;

	mag_sample_dedup_qualifier uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_ready   (data_ready),
		.overflow     (overflow),
		.oneshot      (oneshot),
		.raw_x        (raw_x),
		.raw_y        (raw_y),
		.raw_z        (raw_z),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.reject_reason(reject_reason),
		.field_x      (field_x),
		.field_y      (field_y),
		.field_z      (field_z),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [RAW_W-1:0] rand_raw();
		case ($urandom_range(0, 11))
			0: return 16'sh8000;
			1: return 16'sd32767;
			2: return -16'sd1;
			3: return 16'sd0;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	function automatic mag_sample_t sample_of(int rdy, int ovf, int os,
		int x, int y, int z, logic [TIME_W-1:0] t);
		mag_sample_t s;
		s.data_ready = rdy[0];
		s.overflow = ovf[0];
		s.oneshot = os[0];
		s.x = x[RAW_W-1:0];
		s.y = y[RAW_W-1:0];
		s.z = z[RAW_W-1:0];
		s.now = t;
		return s;
	endfunction

	// result side: check each item taken, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.accepted = accepted;
			seen.reason = msdq_reason_t'(reject_reason);
			seen.fx = field_x;
			seen.fy = field_y;
			seen.fz = field_z;
			sb.check_result(seen);
		end
		if (rx_hold > 0) begin
			rx_hold--;
			out_stall <= 1'b1;
		end else if (rx_idle_on) begin
			rx_len = idle_len();
			rx_hold = (rx_len > 0) ? rx_len - 1 : 0;
			out_stall <= (rx_len > 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_sample(input mag_sample_t s);
		int n;
		in_valid <= 1'b1;
		data_ready <= s.data_ready;
		overflow <= s.overflow;
		oneshot <= s.oneshot;
		raw_x <= s.x;
		raw_y <= s.y;
		raw_z <= s.z;
		now_ms <= s.now;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_sample(s);
		n = tx_idle_on ? idle_len() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [PERIOD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// mostly clean status and repeats of the last sample timed around the
	// suppression window, plus fresh samples, status noise and time jumps
	task automatic next_sample(output mag_sample_t s);
		int                r;
		int unsigned       p;
		int unsigned       thresh;
		logic [TIME_W-1:0] step;
		p = sb.period;
		thresh = p + p / 10;
		r = $urandom_range(0, 99);
		s.oneshot = ($urandom_range(0, 3) == 0);
		s.data_ready = s.oneshot ? 1'($urandom_range(0, 1)) : 1'b1;
		s.overflow = 1'b0;
		s.x = last_x;
		s.y = last_y;
		s.z = last_z;
		if (r < 55) begin
			case ($urandom_range(0, 9))
				0: step = thresh;
				1: step = thresh - 1;
				default: step = $urandom_range(0, 3 * p + 3);
			endcase
		end else if (r < 80) begin
			s.x = rand_raw();
			s.y = rand_raw();
			s.z = rand_raw();
			step = $urandom_range(0, 2 * p + 3);
		end else if (r < 93) begin
			s.data_ready = 1'($urandom_range(0, 1));
			s.overflow = 1'($urandom_range(0, 1));
			s.oneshot = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 1)) begin
				s.x = rand_raw();
				s.y = rand_raw();
				s.z = rand_raw();
			end
			step = $urandom_range(0, p + 3);
		end else begin
			clock_ms = $urandom;
			step = '0;
		end
		clock_ms = clock_ms + step;
		s.now = clock_ms;
		last_x = s.x;
		last_y = s.y;
		last_z = s.z;
	endtask

	initial begin
		int          phase_period[PHASES];
		bit          phase_check[PHASES];
		mag_sample_t s;
		int          leftover;
		int          w;
		int          p;

		phase_period = '{1, 1000, 0, 1023, -1, 10, -1, 50};
		phase_check = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: window and advance, status codes, wrap and backwards time
		send_sample(sample_of(1, 0, 0, 32767, -32768, 0, 0));
		send_sample(sample_of(1, 0, 0, 32767, -32768, 0, 10));
		send_sample(sample_of(1, 0, 0, 32767, -32768, 0, 55));
		send_sample(sample_of(1, 0, 0, 32767, -32768, 0, 104));
		send_sample(sample_of(1, 0, 0, 32767, -32768, 0, 1000));
		send_sample(sample_of(0, 0, 0, 1, 2, 3, 2000));
		send_sample(sample_of(1, 1, 0, 1, 2, 3, 2000));
		send_sample(sample_of(0, 1, 0, 1, 2, 3, 2000));
		send_sample(sample_of(0, 0, 1, -1, 1, -32768, 2100));
		send_sample(sample_of(1, 1, 1, -1, 1, -32768, 2100));
		send_sample(sample_of(1, 0, 0, -1, 1, -32768, 1500));
		send_sample(sample_of(1, 0, 0, 5, 5, 5, 32'hFFFF_FFF0));
		send_sample(sample_of(1, 0, 0, 5, 5, 5, 32'h0000_0010));
		send_sample(sample_of(1, 0, 0, 5, 5, 5, 32'hFFFF_FFFF));
		wait_results_drained();

		// a period write drops the stored sample, so a repeat is new again
		write_reg(CFG_PERIOD, 10'd50);
		send_sample(sample_of(1, 0, 0, 5, 5, 5, 32'hFFFF_FFFF));
		wait_results_drained();

		// zero period and status checks off
		write_reg(CFG_PERIOD, 10'd0);
		write_reg(CFG_CHECK, 10'd0);
		settings_used++;
		send_sample(sample_of(0, 1, 0, 7, -7, 0, 100));
		send_sample(sample_of(0, 1, 0, 7, -7, 0, 100));
		send_sample(sample_of(1, 0, 0, 0, 0, 0, 0));
		send_sample(sample_of(0, 0, 1, 0, 0, 0, 0));
		wait_results_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			p = (phase_period[ph] < 0) ? $urandom_range(2, 999) : phase_period[ph];
			write_reg(CFG_PERIOD, p[PERIOD_W-1:0]);
			write_reg(CFG_CHECK, {{(PERIOD_W-1){1'b0}}, phase_check[ph]});
			settings_used++;
			tx_idle_on = (ph != 5);
			rx_idle_on = (ph != 5);
			clock_ms = $urandom;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				next_sample(s);
				send_sample(s);
				// hold the sender until the pipeline is empty
				if (k == 27)
					wait_results_drained();
			end
			wait_results_drained();
		end

		in_valid <= 1'b0;
		for (w = 0; w < 5000 && sb.waiting() != 0; w++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		leftover = sb.waiting();
		if (leftover != 0)
			$display("%0d results never arrived", leftover);

		$display("Checked %0d samples over %0d register settings", sb.checked, settings_used);
		$display("Outcomes: %0d accepted, %0d not ready, %0d overflow, %0d duplicate",
			sb.reason_count[RSN_OK], sb.reason_count[RSN_NOT_READY],
			sb.reason_count[RSN_OVERFLOW], sb.reason_count[RSN_DUPLICATE]);
		if (sb.errors == 0 && leftover == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", sb.waiting());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
